// ===== rtl/mcte_pkg.sv =====
// Package: shared constants, types and lookup tables of the triangle emitter.
package mcte_pkg;

   // Field widths
   localparam int COORD_W  = 5;
   localparam int PC_W     = COORD_W + 1;
   localparam int DENS_W   = 8;
   localparam int SLOT_W   = 4;
   localparam int ID_W     = 15;
   localparam int POS_W    = 21;
   localparam int FRAC_W   = 17;
   localparam int QUOT_W   = 16;
   localparam int EDGE_W   = 4;
   localparam int ROW_W    = 64;

   localparam int SAMPLES_PER_AXIS_DEF = 32;

   localparam logic [FRAC_W-1:0] ONE_Q16  = 17'h10000;
   // edge codes above this one end a table row
   localparam logic [EDGE_W-1:0] EDGE_MAX = 4'd11;

   // Corner offsets, bit i belongs to corner i
   localparam logic [7:0] CORNER_DX = 8'b0110_0110;
   localparam logic [7:0] CORNER_DY = 8'b1111_0000;
   localparam logic [7:0] CORNER_DZ = 8'b0011_0011;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SETUP,
      ST_ORDER,
      ST_DIV,
      ST_OUT
   } mcte_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic classify;
      logic setup;
      logic order;
      logic div_step;
      logic advance;
   } mcte_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic row_end;
      logic div_done;
   } mcte_status_type;

   // First corner of an edge
   function automatic logic [2:0] edge_from(input logic [EDGE_W-1:0] e);
      logic [2:0] c;
      case (e)
         4'd0:    c = 3'd0;
         4'd1:    c = 3'd1;
         4'd2:    c = 3'd2;
         4'd3:    c = 3'd3;
         4'd4:    c = 3'd4;
         4'd5:    c = 3'd5;
         4'd6:    c = 3'd6;
         4'd7:    c = 3'd7;
         4'd8:    c = 3'd0;
         4'd9:    c = 3'd1;
         4'd10:   c = 3'd2;
         4'd11:   c = 3'd3;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   // Second corner of an edge
   function automatic logic [2:0] edge_to(input logic [EDGE_W-1:0] e);
      logic [2:0] c;
      case (e)
         4'd0:    c = 3'd1;
         4'd1:    c = 3'd2;
         4'd2:    c = 3'd3;
         4'd3:    c = 3'd0;
         4'd4:    c = 3'd5;
         4'd5:    c = 3'd6;
         4'd6:    c = 3'd7;
         4'd7:    c = 3'd4;
         4'd8:    c = 3'd4;
         4'd9:    c = 3'd5;
         4'd10:   c = 3'd6;
         4'd11:   c = 3'd7;
         default: c = 3'd0;
      endcase
      return c;
   endfunction

   // Triangle table: edge codes read from the top nibble down, padded with f
   function automatic logic [ROW_W-1:0] tri_row(input logic [7:0] idx);
      logic [ROW_W-1:0] r;
      case (idx)
         8'd0:   r = 64'hffff_ffff_ffff_ffff;
         8'd1:   r = 64'h083f_ffff_ffff_ffff;
         8'd2:   r = 64'h019f_ffff_ffff_ffff;
         8'd3:   r = 64'h1839_81ff_ffff_ffff;
         8'd4:   r = 64'h12af_ffff_ffff_ffff;
         8'd5:   r = 64'h0831_2aff_ffff_ffff;
         8'd6:   r = 64'h92a0_29ff_ffff_ffff;
         8'd7:   r = 64'h2832_a8a9_8fff_ffff;
         8'd8:   r = 64'h3b2f_ffff_ffff_ffff;
         8'd9:   r = 64'h0b28_b0ff_ffff_ffff;
         8'd10:  r = 64'h1902_3bff_ffff_ffff;
         8'd11:  r = 64'h1b21_9b98_bfff_ffff;
         8'd12:  r = 64'h3a1b_a3ff_ffff_ffff;
         8'd13:  r = 64'h0a10_8a8b_afff_ffff;
         8'd14:  r = 64'h3903_b9ba_9fff_ffff;
         8'd15:  r = 64'h98aa_8bff_ffff_ffff;
         8'd16:  r = 64'h478f_ffff_ffff_ffff;
         8'd17:  r = 64'h4307_34ff_ffff_ffff;
         8'd18:  r = 64'h0198_47ff_ffff_ffff;
         8'd19:  r = 64'h4194_7173_1fff_ffff;
         8'd20:  r = 64'h12a8_47ff_ffff_ffff;
         8'd21:  r = 64'h3473_0412_afff_ffff;
         8'd22:  r = 64'h92a9_0284_7fff_ffff;
         8'd23:  r = 64'h2a92_9727_3794_ffff;
         8'd24:  r = 64'h8473_b2ff_ffff_ffff;
         8'd25:  r = 64'hb47b_2420_4fff_ffff;
         8'd26:  r = 64'h9018_4723_bfff_ffff;
         8'd27:  r = 64'h47b9_4b9b_2921_ffff;
         8'd28:  r = 64'h3a13_ba78_4fff_ffff;
         8'd29:  r = 64'h1ba1_4b10_47b4_ffff;
         8'd30:  r = 64'h4789_0b9b_ab03_ffff;
         8'd31:  r = 64'h47b4_b99b_afff_ffff;
         8'd32:  r = 64'h954f_ffff_ffff_ffff;
         8'd33:  r = 64'h9540_83ff_ffff_ffff;
         8'd34:  r = 64'h0541_50ff_ffff_ffff;
         8'd35:  r = 64'h8548_3531_5fff_ffff;
         8'd36:  r = 64'h12a9_54ff_ffff_ffff;
         8'd37:  r = 64'h3081_2a49_5fff_ffff;
         8'd38:  r = 64'h52a5_4240_2fff_ffff;
         8'd39:  r = 64'h2a53_2535_4348_ffff;
         8'd40:  r = 64'h9542_3bff_ffff_ffff;
         8'd41:  r = 64'h0b20_8b49_5fff_ffff;
         8'd42:  r = 64'h0540_1523_bfff_ffff;
         8'd43:  r = 64'h2152_5828_b485_ffff;
         8'd44:  r = 64'ha3ba_1395_4fff_ffff;
         8'd45:  r = 64'h4950_818a_18ba_ffff;
         8'd46:  r = 64'h5405_0b5b_ab03_ffff;
         8'd47:  r = 64'h5485_8aa8_bfff_ffff;
         8'd48:  r = 64'h9785_79ff_ffff_ffff;
         8'd49:  r = 64'h9309_5357_3fff_ffff;
         8'd50:  r = 64'h0780_1715_7fff_ffff;
         8'd51:  r = 64'h1533_57ff_ffff_ffff;
         8'd52:  r = 64'h9789_57a1_2fff_ffff;
         8'd53:  r = 64'ha129_5053_0573_ffff;
         8'd54:  r = 64'h8028_2585_7a52_ffff;
         8'd55:  r = 64'h2a52_5335_7fff_ffff;
         8'd56:  r = 64'h7957_893b_2fff_ffff;
         8'd57:  r = 64'h9579_7292_027b_ffff;
         8'd58:  r = 64'h23b0_1817_8157_ffff;
         8'd59:  r = 64'hb21b_1771_5fff_ffff;
         8'd60:  r = 64'h9588_57a1_3a3b_ffff;
         8'd61:  r = 64'h5705_097b_010a_ba0f;
         8'd62:  r = 64'hba0b_03a5_0807_570f;
         8'd63:  r = 64'hba57_b5ff_ffff_ffff;
         8'd64:  r = 64'ha65f_ffff_ffff_ffff;
         8'd65:  r = 64'h0835_a6ff_ffff_ffff;
         8'd66:  r = 64'h9015_a6ff_ffff_ffff;
         8'd67:  r = 64'h1831_985a_6fff_ffff;
         8'd68:  r = 64'h1652_61ff_ffff_ffff;
         8'd69:  r = 64'h1651_2630_8fff_ffff;
         8'd70:  r = 64'h9659_0602_6fff_ffff;
         8'd71:  r = 64'h5985_8252_6328_ffff;
         8'd72:  r = 64'h23ba_65ff_ffff_ffff;
         8'd73:  r = 64'hb08b_20a6_5fff_ffff;
         8'd74:  r = 64'h0192_3b5a_6fff_ffff;
         8'd75:  r = 64'h5a61_929b_298b_ffff;
         8'd76:  r = 64'h63b6_5351_3fff_ffff;
         8'd77:  r = 64'h08b0_b505_15b6_ffff;
         8'd78:  r = 64'h3b60_3606_5059_ffff;
         8'd79:  r = 64'h6596_9bb9_8fff_ffff;
         8'd80:  r = 64'h5a64_78ff_ffff_ffff;
         8'd81:  r = 64'h4304_7365_afff_ffff;
         8'd82:  r = 64'h1905_a684_7fff_ffff;
         8'd83:  r = 64'ha651_9717_3794_ffff;
         8'd84:  r = 64'h6126_5147_8fff_ffff;
         8'd85:  r = 64'h1255_2630_4347_ffff;
         8'd86:  r = 64'h8479_0506_5026_ffff;
         8'd87:  r = 64'h7397_9432_9596_269f;
         8'd88:  r = 64'h3b27_84a6_5fff_ffff;
         8'd89:  r = 64'h5a64_7242_027b_ffff;
         8'd90:  r = 64'h0194_7823_b5a6_ffff;
         8'd91:  r = 64'h9219_b294_b7b4_5a6f;
         8'd92:  r = 64'h8473_b535_15b6_ffff;
         8'd93:  r = 64'h51b5_b610_b7b4_04bf;
         8'd94:  r = 64'h0590_6503_6b63_847f;
         8'd95:  r = 64'h6596_9b47_97b9_ffff;
         8'd96:  r = 64'ha496_4aff_ffff_ffff;
         8'd97:  r = 64'h4a64_9a08_3fff_ffff;
         8'd98:  r = 64'ha01a_0664_0fff_ffff;
         8'd99:  r = 64'h8318_1686_461a_ffff;
         8'd100: r = 64'h1491_2426_4fff_ffff;
         8'd101: r = 64'h3081_2924_9264_ffff;
         8'd102: r = 64'h0244_26ff_ffff_ffff;
         8'd103: r = 64'h8328_2442_6fff_ffff;
         8'd104: r = 64'ha49a_64b2_3fff_ffff;
         8'd105: r = 64'h0822_8b49_a4a6_ffff;
         8'd106: r = 64'h3b20_1606_461a_ffff;
         8'd107: r = 64'h6416_1a48_121b_8b1f;
         8'd108: r = 64'h9649_3691_3b63_ffff;
         8'd109: r = 64'h8b18_10b6_1914_641f;
         8'd110: r = 64'h3b63_6006_4fff_ffff;
         8'd111: r = 64'h648b_68ff_ffff_ffff;
         8'd112: r = 64'h7a67_8a89_afff_ffff;
         8'd113: r = 64'h0730_a709_a67a_ffff;
         8'd114: r = 64'ha671_a717_8180_ffff;
         8'd115: r = 64'ha67a_7117_3fff_ffff;
         8'd116: r = 64'h1261_6818_9867_ffff;
         8'd117: r = 64'h2692_9167_9093_739f;
         8'd118: r = 64'h7807_0660_2fff_ffff;
         8'd119: r = 64'h7326_72ff_ffff_ffff;
         8'd120: r = 64'h23ba_68a8_9867_ffff;
         8'd121: r = 64'h2072_7b09_767a_9a7f;
         8'd122: r = 64'h1801_781a_767a_23bf;
         8'd123: r = 64'hb21b_17a6_1671_ffff;
         8'd124: r = 64'h8968_6791_6b63_136f;
         8'd125: r = 64'h091b_67ff_ffff_ffff;
         8'd126: r = 64'h7807_063b_0b60_ffff;
         8'd127: r = 64'h7b6f_ffff_ffff_ffff;
         8'd128: r = 64'h76bf_ffff_ffff_ffff;
         8'd129: r = 64'h308b_76ff_ffff_ffff;
         8'd130: r = 64'h019b_76ff_ffff_ffff;
         8'd131: r = 64'h8198_31b7_6fff_ffff;
         8'd132: r = 64'ha126_b7ff_ffff_ffff;
         8'd133: r = 64'h12a3_086b_7fff_ffff;
         8'd134: r = 64'h2902_a96b_7fff_ffff;
         8'd135: r = 64'h6b72_a3a8_3a98_ffff;
         8'd136: r = 64'h7236_27ff_ffff_ffff;
         8'd137: r = 64'h7087_6062_0fff_ffff;
         8'd138: r = 64'h2762_3701_9fff_ffff;
         8'd139: r = 64'h1621_8619_8876_ffff;
         8'd140: r = 64'ha76a_1713_7fff_ffff;
         8'd141: r = 64'ha761_7a18_7108_ffff;
         8'd142: r = 64'h0370_7a0a_96a7_ffff;
         8'd143: r = 64'h76a7_a88a_9fff_ffff;
         8'd144: r = 64'h684b_86ff_ffff_ffff;
         8'd145: r = 64'h36b3_0604_6fff_ffff;
         8'd146: r = 64'h86b8_4690_1fff_ffff;
         8'd147: r = 64'h9469_6393_1b36_ffff;
         8'd148: r = 64'h6846_b82a_1fff_ffff;
         8'd149: r = 64'h12a3_0b06_b046_ffff;
         8'd150: r = 64'h4b84_6b02_92a9_ffff;
         8'd151: r = 64'ha93a_3294_3b36_463f;
         8'd152: r = 64'h8238_4246_2fff_ffff;
         8'd153: r = 64'h0424_62ff_ffff_ffff;
         8'd154: r = 64'h1902_3424_6438_ffff;
         8'd155: r = 64'h1941_4224_6fff_ffff;
         8'd156: r = 64'h8138_6184_66a1_ffff;
         8'd157: r = 64'ha10a_0660_4fff_ffff;
         8'd158: r = 64'h4634_386a_3039_a93f;
         8'd159: r = 64'ha946_a4ff_ffff_ffff;
         8'd160: r = 64'h4957_6bff_ffff_ffff;
         8'd161: r = 64'h0834_95b7_6fff_ffff;
         8'd162: r = 64'h5015_4076_bfff_ffff;
         8'd163: r = 64'hb768_3435_4315_ffff;
         8'd164: r = 64'h954a_1276_bfff_ffff;
         8'd165: r = 64'h6b71_2a08_3495_ffff;
         8'd166: r = 64'h76b5_4a42_a402_ffff;
         8'd167: r = 64'h3483_5432_5a52_b76f;
         8'd168: r = 64'h7237_6254_9fff_ffff;
         8'd169: r = 64'h9540_8606_2687_ffff;
         8'd170: r = 64'h3623_7615_0540_ffff;
         8'd171: r = 64'h6286_8721_8485_158f;
         8'd172: r = 64'h954a_1617_6137_ffff;
         8'd173: r = 64'h16a1_7610_7870_954f;
         8'd174: r = 64'h40a4_a503_a6a7_37af;
         8'd175: r = 64'h76a7_a854_a48a_ffff;
         8'd176: r = 64'h6956_b9b8_9fff_ffff;
         8'd177: r = 64'h36b0_6305_6095_ffff;
         8'd178: r = 64'h0b80_5b01_556b_ffff;
         8'd179: r = 64'h6b36_3553_1fff_ffff;
         8'd180: r = 64'h12a9_5b9b_8b56_ffff;
         8'd181: r = 64'h0b30_6b09_6569_12af;
         8'd182: r = 64'hb85b_5680_5a52_025f;
         8'd183: r = 64'h6b36_352a_3a53_ffff;
         8'd184: r = 64'h5895_2856_2382_ffff;
         8'd185: r = 64'h9569_6006_2fff_ffff;
         8'd186: r = 64'h1581_8056_8382_628f;
         8'd187: r = 64'h1562_16ff_ffff_ffff;
         8'd188: r = 64'h1361_6a38_6569_896f;
         8'd189: r = 64'ha10a_0695_0560_ffff;
         8'd190: r = 64'h0385_6aff_ffff_ffff;
         8'd191: r = 64'ha56f_ffff_ffff_ffff;
         8'd192: r = 64'hb5a7_5bff_ffff_ffff;
         8'd193: r = 64'hb5ab_7583_0fff_ffff;
         8'd194: r = 64'h5b75_ab19_0fff_ffff;
         8'd195: r = 64'ha75a_b798_1831_ffff;
         8'd196: r = 64'hb12b_1775_1fff_ffff;
         8'd197: r = 64'h0831_2717_572b_ffff;
         8'd198: r = 64'h9759_2790_22b7_ffff;
         8'd199: r = 64'h7527_2b59_2328_982f;
         8'd200: r = 64'h25a2_3537_5fff_ffff;
         8'd201: r = 64'h8208_5287_5a25_ffff;
         8'd202: r = 64'h9015_a353_73a2_ffff;
         8'd203: r = 64'h9829_2187_2a25_752f;
         8'd204: r = 64'h1353_75ff_ffff_ffff;
         8'd205: r = 64'h0870_7117_5fff_ffff;
         8'd206: r = 64'h9039_3553_7fff_ffff;
         8'd207: r = 64'h9875_97ff_ffff_ffff;
         8'd208: r = 64'h5845_a8ab_8fff_ffff;
         8'd209: r = 64'h5045_b05a_bb30_ffff;
         8'd210: r = 64'h0198_4a8a_ba45_ffff;
         8'd211: r = 64'hab4a_45b3_4941_314f;
         8'd212: r = 64'h2512_852b_8458_ffff;
         8'd213: r = 64'h04b0_b345_b2b1_51bf;
         8'd214: r = 64'h0250_592b_5458_b85f;
         8'd215: r = 64'h9452_b3ff_ffff_ffff;
         8'd216: r = 64'h25a3_5235_4384_ffff;
         8'd217: r = 64'h5a25_2442_0fff_ffff;
         8'd218: r = 64'h3a23_5a38_5458_019f;
         8'd219: r = 64'h5a25_2419_2942_ffff;
         8'd220: r = 64'h8458_5335_1fff_ffff;
         8'd221: r = 64'h0451_05ff_ffff_ffff;
         8'd222: r = 64'h8458_5390_5035_ffff;
         8'd223: r = 64'h945f_ffff_ffff_ffff;
         8'd224: r = 64'h4b74_9b9a_bfff_ffff;
         8'd225: r = 64'h0834_979b_79ab_ffff;
         8'd226: r = 64'h1ab1_b414_074b_ffff;
         8'd227: r = 64'h3143_481a_474b_ab4f;
         8'd228: r = 64'h4b79_b492_b912_ffff;
         8'd229: r = 64'h9749_b791_b2b1_083f;
         8'd230: r = 64'hb74b_4224_0fff_ffff;
         8'd231: r = 64'hb74b_4283_4324_ffff;
         8'd232: r = 64'h29a2_7923_7749_ffff;
         8'd233: r = 64'h9a79_74a2_7870_207f;
         8'd234: r = 64'h37a3_a274_a1a0_40af;
         8'd235: r = 64'h1a28_74ff_ffff_ffff;
         8'd236: r = 64'h4914_1771_3fff_ffff;
         8'd237: r = 64'h4914_1708_1871_ffff;
         8'd238: r = 64'h4037_43ff_ffff_ffff;
         8'd239: r = 64'h487f_ffff_ffff_ffff;
         8'd240: r = 64'h9a8a_b8ff_ffff_ffff;
         8'd241: r = 64'h3093_9bb9_afff_ffff;
         8'd242: r = 64'h01a0_a88a_bfff_ffff;
         8'd243: r = 64'h31ab_3aff_ffff_ffff;
         8'd244: r = 64'h12b1_b99b_8fff_ffff;
         8'd245: r = 64'h3093_9b12_92b9_ffff;
         8'd246: r = 64'h02b8_0bff_ffff_ffff;
         8'd247: r = 64'h32bf_ffff_ffff_ffff;
         8'd248: r = 64'h2382_8aa8_9fff_ffff;
         8'd249: r = 64'h9a20_92ff_ffff_ffff;
         8'd250: r = 64'h2382_8a01_81a8_ffff;
         8'd251: r = 64'h1a2f_ffff_ffff_ffff;
         8'd252: r = 64'h1389_18ff_ffff_ffff;
         8'd253: r = 64'h091f_ffff_ffff_ffff;
         8'd254: r = 64'h038f_ffff_ffff_ffff;
         default: r = 64'hffff_ffff_ffff_ffff;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/mcte_if.sv =====
// Interfaces: cube request, vertex result and cutoff write channels.
interface mcte_req_if import mcte_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [COORD_W-1:0]       cube_x;
   logic [COORD_W-1:0]       cube_y;
   logic [COORD_W-1:0]       cube_z;
   logic signed [DENS_W-1:0] density_c0;
   logic signed [DENS_W-1:0] density_c1;
   logic signed [DENS_W-1:0] density_c2;
   logic signed [DENS_W-1:0] density_c3;
   logic signed [DENS_W-1:0] density_c4;
   logic signed [DENS_W-1:0] density_c5;
   logic signed [DENS_W-1:0] density_c6;
   logic signed [DENS_W-1:0] density_c7;

   modport source (output valid, cube_x, cube_y, cube_z, density_c0, density_c1,
                   density_c2, density_c3, density_c4, density_c5, density_c6,
                   density_c7, input ready);
   modport sink (input valid, cube_x, cube_y, cube_z, density_c0, density_c1,
                 density_c2, density_c3, density_c4, density_c5, density_c6,
                 density_c7, output ready);
endinterface

interface mcte_rsp_if import mcte_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] vertex_slot;
   logic [ID_W-1:0]   low_sample_id;
   logic [ID_W-1:0]   high_sample_id;
   logic [POS_W-1:0]  pos_x;
   logic [POS_W-1:0]  pos_y;
   logic [POS_W-1:0]  pos_z;
   logic              last_vertex;

   modport source (output valid, vertex_slot, low_sample_id, high_sample_id, pos_x,
                   pos_y, pos_z, last_vertex, input ready);
   modport sink (input valid, vertex_slot, low_sample_id, high_sample_id, pos_x,
                 pos_y, pos_z, last_vertex, output ready);
endinterface

interface mcte_csr_if import mcte_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DENS_W-1:0] surface_cutoff;

   modport source (output valid, surface_cutoff, input ready);
   modport sink (input valid, surface_cutoff, output ready);
endinterface

// ===== rtl/mcte_ctrl.sv =====
// Controller: sequences classify, per-vertex setup, division and output.
module mcte_ctrl import mcte_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  mcte_status_type status,
   output mcte_cmd_type    cmd
);

   mcte_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in     = ST_SETUP;
         end
         ST_SETUP: begin
            // end of the row: the cube is finished
            if (status.row_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.setup = 1'b1;
               state_in  = ST_ORDER;
            end
         end
         ST_ORDER: begin
            cmd.order = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/mcte_datapath.sv =====
// Datapath: case index, edge walk, sample ids and Q16 interpolation divider.
module mcte_datapath import mcte_pkg::*; #(
   parameter int SAMPLES_PER_AXIS = SAMPLES_PER_AXIS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mcte_cmd_type                   cmd,
   output mcte_status_type                status,
   input  logic                           csr_write,
   input  logic [DENS_W-1:0]              csr_data,
   input  logic [COORD_W-1:0]             req_x,
   input  logic [COORD_W-1:0]             req_y,
   input  logic [COORD_W-1:0]             req_z,
   input  logic [7:0][DENS_W-1:0]         req_dens,
   output logic [SLOT_W-1:0]              rsp_slot,
   output logic [ID_W-1:0]                rsp_low_id,
   output logic [ID_W-1:0]                rsp_high_id,
   output logic [POS_W-1:0]               rsp_pos_x,
   output logic [POS_W-1:0]               rsp_pos_y,
   output logic [POS_W-1:0]               rsp_pos_z,
   output logic                           rsp_last
);

   localparam int SS        = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;
   localparam int ID_FULL_W = $clog2(32 * (1 + SAMPLES_PER_AXIS + SS) + 1);
   localparam int BASE_W    = PC_W + 16;

   typedef enum logic [1:0] {FRAC_ZERO, FRAC_FULL, FRAC_DIV} frac_mode_type;
   typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_type;

   // Cutoff register
   logic [DENS_W-1:0] cutoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= '0;
      end else if (csr_write) begin
         cutoff_ff <= csr_data;
      end
   end

   // Cube latch, row and slot
   logic [COORD_W-1:0]     x_ff, y_ff, z_ff;
   logic [7:0][DENS_W-1:0] dens_ff;
   logic [ROW_W-1:0]       row_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [7:0]             case_idx;
   logic [SLOT_W-1:0]      slot_nxt;
   logic [EDGE_W-1:0]      edge_cur, edge_nxt;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         case_idx[i] = $signed(dens_ff[i]) >= $signed(cutoff_ff);
      end
   end

   assign slot_nxt = slot_ff + 1'b1;
   assign edge_cur = row_ff[{~slot_ff, 2'b00} +: EDGE_W];
   assign edge_nxt = row_ff[{~slot_nxt, 2'b00} +: EDGE_W];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_x;
         y_ff    <= req_y;
         z_ff    <= req_z;
         dens_ff <= req_dens;
      end
      if (cmd.classify) begin
         row_ff <= tri_row(case_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (cmd.classify) begin
         slot_ff <= '0;
      end else if (cmd.advance) begin
         slot_ff <= slot_nxt;
      end
   end

   // Edge setup: both endpoints and their sample ids
   logic [2:0]              corner_a, corner_b;
   logic [PC_W-1:0]         ax_in, ay_in, az_in, bx_in, by_in, bz_in;
   logic [PC_W-1:0]         ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic [ID_FULL_W-1:0]    id_a_ff, id_b_ff;
   logic [DENS_W-1:0]       da_ff, db_ff;

   assign corner_a = edge_from(edge_cur);
   assign corner_b = edge_to(edge_cur);
   assign ax_in = {1'b0, x_ff} + PC_W'(CORNER_DX[corner_a]);
   assign ay_in = {1'b0, y_ff} + PC_W'(CORNER_DY[corner_a]);
   assign az_in = {1'b0, z_ff} + PC_W'(CORNER_DZ[corner_a]);
   assign bx_in = {1'b0, x_ff} + PC_W'(CORNER_DX[corner_b]);
   assign by_in = {1'b0, y_ff} + PC_W'(CORNER_DY[corner_b]);
   assign bz_in = {1'b0, z_ff} + PC_W'(CORNER_DZ[corner_b]);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         az_ff   <= az_in;
         bx_ff   <= bx_in;
         by_ff   <= by_in;
         bz_ff   <= bz_in;
         id_a_ff <= ID_FULL_W'(ay_in) + ID_FULL_W'(ax_in) * ID_FULL_W'(SAMPLES_PER_AXIS)
                    + ID_FULL_W'(az_in) * ID_FULL_W'(SS);
         id_b_ff <= ID_FULL_W'(by_in) + ID_FULL_W'(bx_in) * ID_FULL_W'(SAMPLES_PER_AXIS)
                    + ID_FULL_W'(bz_in) * ID_FULL_W'(SS);
         da_ff   <= dens_ff[corner_a];
         db_ff   <= dens_ff[corner_b];
      end
   end

   // Ordering: lower id first, then numerator and denominator
   logic                     a_first;
   logic [DENS_W-1:0]        d_lo, d_hi;
   logic signed [DENS_W:0]   num_raw, den_raw, num_n, den_n;
   frac_mode_type            mode_in;
   axis_type                 axis_in;

   assign a_first = id_a_ff <= id_b_ff;
   assign d_lo    = a_first ? da_ff : db_ff;
   assign d_hi    = a_first ? db_ff : da_ff;

   always_comb begin
      num_raw = $signed({cutoff_ff[DENS_W-1], cutoff_ff}) - $signed({d_lo[DENS_W-1], d_lo});
      den_raw = $signed({d_hi[DENS_W-1], d_hi}) - $signed({d_lo[DENS_W-1], d_lo});
      if (den_raw < 0) begin
         num_n = -num_raw;
         den_n = -den_raw;
      end else begin
         num_n = num_raw;
         den_n = den_raw;
      end
      if (den_n == 0 || num_n < 0) begin
         mode_in = FRAC_ZERO;
      end else if (num_n >= den_n) begin
         mode_in = FRAC_FULL;
      end else begin
         mode_in = FRAC_DIV;
      end
      if (ax_ff != bx_ff) begin
         axis_in = AXIS_X;
      end else if (ay_ff != by_ff) begin
         axis_in = AXIS_Y;
      end else begin
         axis_in = AXIS_Z;
      end
   end

   logic [PC_W-1:0]     lo_x_ff, lo_y_ff, lo_z_ff;
   logic [ID_W-1:0]     id_lo_ff, id_hi_ff;
   frac_mode_type       mode_ff;
   axis_type            axis_ff;
   logic [DENS_W-1:0]   den_ff, rem_ff, rem_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [1:0]          cnt_ff;

   // Long division, four quotient bits a cycle
   always_comb begin
      logic [DENS_W:0] t;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      for (int i = 0; i < 4; i++) begin
         t = {rem_in, 1'b0};
         if (t >= {1'b0, den_ff}) begin
            t       = t - {1'b0, den_ff};
            quot_in = {quot_in[QUOT_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_in[QUOT_W-2:0], 1'b0};
         end
         rem_in = t[DENS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.order) begin
         lo_x_ff  <= a_first ? ax_ff : bx_ff;
         lo_y_ff  <= a_first ? ay_ff : by_ff;
         lo_z_ff  <= a_first ? az_ff : bz_ff;
         id_lo_ff <= a_first ? id_a_ff[ID_W-1:0] : id_b_ff[ID_W-1:0];
         id_hi_ff <= a_first ? id_b_ff[ID_W-1:0] : id_a_ff[ID_W-1:0];
         mode_ff  <= mode_in;
         axis_ff  <= axis_in;
         den_ff   <= den_n[DENS_W-1:0];
         rem_ff   <= num_n[DENS_W-1:0];
         quot_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff   <= rem_in;
         quot_ff  <= quot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.order) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign status.row_end  = edge_cur > EDGE_MAX;
   assign status.div_done = cnt_ff == 2'd3;

   // Result positions, written on the last division step
   logic [FRAC_W-1:0] frac;
   logic [BASE_W-1:0] px_in, py_in, pz_in;

   always_comb begin
      case (mode_ff)
         FRAC_FULL: frac = ONE_Q16;
         FRAC_DIV:  frac = {1'b0, quot_in};
         default:   frac = '0;
      endcase
      px_in = {lo_x_ff, 16'b0} + ((axis_ff == AXIS_X) ? BASE_W'(frac) : '0);
      py_in = {lo_y_ff, 16'b0} + ((axis_ff == AXIS_Y) ? BASE_W'(frac) : '0);
      pz_in = {lo_z_ff, 16'b0} + ((axis_ff == AXIS_Z) ? BASE_W'(frac) : '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step && status.div_done) begin
         rsp_slot    <= slot_ff;
         rsp_low_id  <= id_lo_ff;
         rsp_high_id <= id_hi_ff;
         rsp_pos_x   <= px_in[POS_W-1:0];
         rsp_pos_y   <= py_in[POS_W-1:0];
         rsp_pos_z   <= pz_in[POS_W-1:0];
         rsp_last    <= edge_nxt > EDGE_MAX;
      end
   end

endmodule

// ===== rtl/marching_cubes_triangle_emitter.sv =====
// Top level: marching-cubes triangle emitter, controller plus datapath.
//
//  channel  | dir | handshake       | content
//  ---------+-----+-----------------+-------------------------------------------
//  req_ch   | in  | valid / ready   | one cube: origin and eight corner densities
//  rsp_ch   | out | valid / ready   | one triangle vertex: slot, sample ids, Q16 pos
//  csr_ch   | in  | valid / ready=1 | surface_cutoff write
//
//  Each cube is classified, then its vertices go out one at a time: each vertex
//  passes edge setup, ordering, the interpolation divider (4 quotient bits a cycle)
//  and the output register, which holds it while the result side stalls. Only one
//  cube is in flight at a time; reset is synchronous and returns the controller
//  to idle and the cutoff to 0.
module marching_cubes_triangle_emitter import mcte_pkg::*; #(
   parameter int SAMPLES_PER_AXIS = SAMPLES_PER_AXIS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mcte_req_if.sink   req_ch,
   mcte_rsp_if.source rsp_ch,
   mcte_csr_if.sink   csr_ch
);

   mcte_cmd_type           cmd;
   mcte_status_type        status;
   logic [7:0][DENS_W-1:0] dens;

   assign csr_ch.ready = 1'b1;
   assign dens = {req_ch.density_c7, req_ch.density_c6, req_ch.density_c5,
                  req_ch.density_c4, req_ch.density_c3, req_ch.density_c2,
                  req_ch.density_c1, req_ch.density_c0};

   // Controller
   mcte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath
   mcte_datapath #(
      .SAMPLES_PER_AXIS (SAMPLES_PER_AXIS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_write   (csr_ch.valid && csr_ch.ready),
      .csr_data    (csr_ch.surface_cutoff),
      .req_x       (req_ch.cube_x),
      .req_y       (req_ch.cube_y),
      .req_z       (req_ch.cube_z),
      .req_dens    (dens),
      .rsp_slot    (rsp_ch.vertex_slot),
      .rsp_low_id  (rsp_ch.low_sample_id),
      .rsp_high_id (rsp_ch.high_sample_id),
      .rsp_pos_x   (rsp_ch.pos_x),
      .rsp_pos_y   (rsp_ch.pos_y),
      .rsp_pos_z   (rsp_ch.pos_z),
      .rsp_last    (rsp_ch.last_vertex)
   );

   // A new request is never taken while a vertex is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request accepted while a vertex is pending");

   // A vertex cannot appear the cycle after a request is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !rsp_ch.valid)
      else $error("vertex shown straight after request");

   // A run ends on a whole triangle
   a_last_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.last_vertex) |->
         (rsp_ch.vertex_slot == 4'd2 || rsp_ch.vertex_slot == 4'd5 ||
          rsp_ch.vertex_slot == 4'd8 || rsp_ch.vertex_slot == 4'd11 ||
          rsp_ch.vertex_slot == 4'd14))
      else $error("last vertex ends a partial triangle");

endmodule

// ===== test/marching_cubes_triangle_emitter_test.sv =====
// Testbench for the marching-cubes triangle emitter: random and directed cubes, scoreboard check.
`timescale 1ns / 1ps

module marching_cubes_triangle_emitter_test;
   import mcte_pkg::*;

   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 120;
   localparam int HOLD_CYCLES = 400;
   localparam int SAMPLES     = 32;
   localparam int MAX_VERTS   = 15;

   // corner offsets and edge endpoints
   localparam int CDX[8] = '{0, 1, 1, 0, 0, 1, 1, 0};
   localparam int CDY[8] = '{0, 0, 0, 0, 1, 1, 1, 1};
   localparam int CDZ[8] = '{1, 1, 0, 0, 1, 1, 0, 0};
   localparam int EDGE_A[12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
   localparam int EDGE_B[12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

   typedef struct {
      logic [COORD_W-1:0]       x;
      logic [COORD_W-1:0]       y;
      logic [COORD_W-1:0]       z;
      logic signed [DENS_W-1:0] d [8];
   } cube_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [ID_W-1:0]   lo_id;
      logic [ID_W-1:0]   hi_id;
      logic [POS_W-1:0]  px;
      logic [POS_W-1:0]  py;
      logic [POS_W-1:0]  pz;
      logic              last;
   } vertex_type;

   // crossed edges per case, three per triangle
   string tri_edges[256] = '{
    "", "083", "019", "183981", "12a", "08312a", "92a029", "2832a8a98",
    "3b2", "0b28b0", "19023b", "1b219b98b", "3a1ba3", "0a108a8ba", "3903b9ba9", "98aa8b",
    "478", "430734", "019847", "419471731", "12a847", "34730412a", "92a902847", "2a9297273794",
    "8473b2", "b47b24204", "90184723b", "47b94b9b2921", "3a13ba784", "1ba14b1047b4",
    "47890b9bab03", "47b4b99ba",
    "954", "954083", "054150", "854835315", "12a954", "30812a495", "52a542402", "2a5325354348",
    "95423b", "0b208b495", "05401523b", "21525828b485", "a3ba13954", "4950818a18ba",
    "54050b5bab03", "54858aa8b",
    "978579", "930953573", "078017157", "153357", "978957a12", "a12950530573", "802825857a52",
    "2a5253357",
    "7957893b2", "95797292027b", "23b018178157", "b21b17715", "958857a13a3b",
    "5705097b010aba0", "ba0b03a50807570", "ba57b5",
    "a65", "0835a6", "9015a6", "1831985a6", "165261", "165126308", "965906026", "598582526328",
    "23ba65", "b08b20a65", "01923b5a6", "5a61929b298b", "63b653513", "08b0b50515b6",
    "3b6036065059", "65969bb98",
    "5a6478", "43047365a", "1905a6847", "a65197173794", "612651478", "125526304347",
    "847905065026", "739794329596269",
    "3b2784a65", "5a647242027b", "01947823b5a6", "9219b294b7b45a6", "8473b53515b6",
    "51b5b610b7b404b", "059065036b63847", "65969b4797b9",
    "a4964a", "4a649a083", "a01a06640", "83181686461a", "149124264", "308129249264", "024426",
    "832824426",
    "a49a64b23", "08228b49a4a6", "3b201606461a", "64161a48121b8b1", "964936913b63",
    "8b1810b61914641", "3b6360064", "648b68",
    "7a678a89a", "0730a709a67a", "a671a7178180", "a67a71173", "126168189867", "269291679093739",
    "780706602", "732672",
    "23ba68a89867", "20727b09767a9a7", "1801781a767a23b", "b21b17a61671", "896867916b63136",
    "091b67", "7807063b0b60", "7b6",
    "76b", "308b76", "019b76", "819831b76", "a126b7", "12a3086b7", "2902a96b7", "6b72a3a83a98",
    "723627", "708760620", "276237019", "162186198876", "a76a17137", "a7617a187108",
    "03707a0a96a7", "76a7a88a9",
    "684b86", "36b306046", "86b846901", "946963931b36", "6846b82a1", "12a30b06b046",
    "4b846b0292a9", "a93a32943b36463",
    "823842462", "042462", "190234246438", "194142246", "8138618466a1", "a10a06604",
    "4634386a3039a93", "a946a4",
    "49576b", "083495b76", "50154076b", "b76834354315", "954a1276b", "6b712a083495",
    "76b54a42a402", "348354325a52b76",
    "723762549", "954086062687", "362376150540", "628687218485158", "954a16176137",
    "16a176107870954", "40a4a503a6a737a", "76a7a854a48a",
    "6956b9b89", "36b063056095", "0b805b01556b", "6b3635531", "12a95b9b8b56",
    "0b306b09656912a", "b85b56805a52025", "6b36352a3a53",
    "589528562382", "956960062", "158180568382628", "156216", "13616a386569896",
    "a10a06950560", "03856a", "a56",
    "b5a75b", "b5ab75830", "5b75ab190", "a75ab7981831", "b12b17751", "08312717572b",
    "9759279022b7", "75272b592328982",
    "25a235375", "820852875a25", "9015a35373a2", "982921872a25752", "135375", "087071175",
    "903935537", "987597",
    "5845a8ab8", "5045b05abb30", "01984a8aba45", "ab4a45b34941314", "2512852b8458",
    "04b0b345b2b151b", "0250592b5458b85", "9452b3",
    "25a352354384", "5a2524420", "3a235a385458019", "5a2524192942", "845853351", "045105",
    "845853905035", "945",
    "4b749b9ab", "0834979b79ab", "1ab1b414074b", "3143481a474bab4", "4b79b492b912",
    "9749b791b2b1083", "b74b42240", "b74b42834324",
    "29a279237749", "9a7974a27870207", "37a3a274a1a040a", "1a2874", "491417713", "491417081871",
    "403743", "487",
    "9a8ab8", "30939bb9a", "01a0a88ab", "31ab3a", "12b1b99b8", "30939b1292b9", "02b80b", "32b",
    "23828aa89", "9a2092", "23828a0181a8", "1a2", "138918", "091", "038", ""
   };

   // Expected vertices and their check against the block
   class vertex_board;
      vertex_type               pending_verts[$];
      logic signed [DENS_W-1:0] cutoff;
      int                       errors;

      function void note_cube(cube_type c);
         int    cs, n, e, lo, hi, tmp, id_lo, id_hi, num, den, frac;
         int    xl, yl, zl;
         byte   ch;
         string row;
         vertex_type v;
         cs = 0;
         for (int k = 0; k < 8; k++)
            if (c.d[k] >= cutoff) cs |= 1 << k;
         row = tri_edges[cs];
         n = (row.len() > MAX_VERTS) ? MAX_VERTS : row.len();
         for (int k = 0; k < n; k++) begin
            ch = row[k];
            e = (ch >= 8'h61) ? ch - 8'h61 + 10 : ch - 8'h30;
            lo = EDGE_A[e];
            hi = EDGE_B[e];
            id_lo = (c.y + CDY[lo]) + (c.x + CDX[lo]) * SAMPLES
                    + (c.z + CDZ[lo]) * SAMPLES * SAMPLES;
            id_hi = (c.y + CDY[hi]) + (c.x + CDX[hi]) * SAMPLES
                    + (c.z + CDZ[hi]) * SAMPLES * SAMPLES;
            if (id_lo > id_hi) begin
               tmp = id_lo; id_lo = id_hi; id_hi = tmp;
               tmp = lo; lo = hi; hi = tmp;
            end
            // interpolate from the lower-id end, truncating
            num = int'(cutoff) - int'(c.d[lo]);
            den = int'(c.d[hi]) - int'(c.d[lo]);
            if (den < 0) begin
               num = -num;
               den = -den;
            end
            frac = 0;
            if (den != 0 && num >= 0) begin
               frac = (num * 65536) / den;
               if (frac > 65536) frac = 65536;
            end
            xl = (c.x + CDX[lo]) << 16;
            yl = (c.y + CDY[lo]) << 16;
            zl = (c.z + CDZ[lo]) << 16;
            if (CDX[lo] != CDX[hi]) xl += frac;
            else if (CDY[lo] != CDY[hi]) yl += frac;
            else zl += frac;
            v.slot  = k[SLOT_W-1:0];
            v.lo_id = id_lo[ID_W-1:0];
            v.hi_id = id_hi[ID_W-1:0];
            v.px    = xl[POS_W-1:0];
            v.py    = yl[POS_W-1:0];
            v.pz    = zl[POS_W-1:0];
            v.last  = (k == n - 1);
            pending_verts = {pending_verts, v};
         end
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type want;
         if (pending_verts.size() == 0) begin
            $error("vertex with none expected: slot %0d", got.slot);
            errors++;
            return;
         end
         want = pending_verts.pop_front();
         if (got.slot !== want.slot) begin
            $error("vertex_slot expected %0d actual %0d", want.slot, got.slot); errors++;
         end
         if (got.lo_id !== want.lo_id) begin
            $error("low_sample_id expected %0d actual %0d", want.lo_id, got.lo_id); errors++;
         end
         if (got.hi_id !== want.hi_id) begin
            $error("high_sample_id expected %0d actual %0d", want.hi_id, got.hi_id); errors++;
         end
         if (got.px !== want.px) begin
            $error("pos_x expected %0d actual %0d", want.px, got.px); errors++;
         end
         if (got.py !== want.py) begin
            $error("pos_y expected %0d actual %0d", want.py, got.py); errors++;
         end
         if (got.pz !== want.pz) begin
            $error("pos_z expected %0d actual %0d", want.pz, got.pz); errors++;
         end
         if (got.last !== want.last) begin
            $error("last_vertex expected %0d actual %0d", want.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   mcte_req_if req_ch ();
   mcte_rsp_if rsp_ch ();
   mcte_csr_if csr_ch ();

   vertex_board board;
   int send_idle_pct;
   int rsp_stall_pct;
   int hold_asked;
   int hold_served;
   int quiet_cycles;

   marching_cubes_triangle_emitter u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      int hold_left;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      vertex_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.slot  = rsp_ch.vertex_slot;
         got.lo_id = rsp_ch.low_sample_id;
         got.hi_id = rsp_ch.high_sample_id;
         got.px    = rsp_ch.pos_x;
         got.py    = rsp_ch.pos_y;
         got.pz    = rsp_ch.pos_z;
         got.last  = rsp_ch.last_vertex;
         board.check_vertex(got);
      end
   end

   // Watchdog on handshake-free cycles
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("marching_cubes_triangle_emitter verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_cube(cube_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.cube_x     <= c.x;
      req_ch.cube_y     <= c.y;
      req_ch.cube_z     <= c.z;
      req_ch.density_c0 <= c.d[0];
      req_ch.density_c1 <= c.d[1];
      req_ch.density_c2 <= c.d[2];
      req_ch.density_c3 <= c.d[3];
      req_ch.density_c4 <= c.d[4];
      req_ch.density_c5 <= c.d[5];
      req_ch.density_c6 <= c.d[6];
      req_ch.density_c7 <= c.d[7];
      req_ch.valid      <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_cube(c);
   endtask

   // Cutoff write, only with the block drained
   task automatic write_cutoff(logic signed [DENS_W-1:0] level);
      req_ch.valid <= 1'b0;
      while (board.pending_verts.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_ch.surface_cutoff <= level;
      csr_ch.valid          <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      board.cutoff = level;
   endtask

   // Cube whose inside corners follow a case mask
   function automatic cube_type case_cube(int mask, int x, int y, int z,
                                          int hi_d, int lo_d);
      cube_type c;
      c.x = x[COORD_W-1:0];
      c.y = y[COORD_W-1:0];
      c.z = z[COORD_W-1:0];
      for (int k = 0; k < 8; k++) c.d[k] = mask[k] ? hi_d[7:0] : lo_d[7:0];
      return c;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      return ($urandom_range(9) == 0) ? COORD_W'($urandom_range(31, 30))
                                      : COORD_W'($urandom_range(29));
   endfunction

   // Random cube: each density near the cutoff about half the time so that edges cross
   function automatic cube_type rand_cube(int level);
      cube_type c;
      int       v;
      c.x = rand_coord();
      c.y = rand_coord();
      c.z = rand_coord();
      for (int k = 0; k < 8; k++) begin
         if ($urandom_range(1) == 0) begin
            v = $urandom_range(255) - 128;
         end else begin
            v = level + $urandom_range(12) - 6;
            if (v > 127) v = 127;
            if (v < -128) v = -128;
         end
         c.d[k] = v[7:0];
      end
      return c;
   endfunction

   initial begin
      int cut_set[5];
      int idle_set[5];
      int stall_set[5];
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cube_x = '0;
      req_ch.cube_y = '0;
      req_ch.cube_z = '0;
      req_ch.density_c0 = '0;
      req_ch.density_c1 = '0;
      req_ch.density_c2 = '0;
      req_ch.density_c3 = '0;
      req_ch.density_c4 = '0;
      req_ch.density_c5 = '0;
      req_ch.density_c6 = '0;
      req_ch.density_c7 = '0;
      csr_ch.valid = 1'b0;
      csr_ch.surface_cutoff = '0;
      rsp_stall_pct = 0;
      send_idle_pct = 0;
      hold_asked = 0;
      hold_served = 0;
      quiet_cycles = 0;
      board = new();
      board.cutoff = 0;
      board.errors = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cubes at reset cutoff
      send_cube(case_cube(8'hff, 0, 0, 0, 0, 0));       // all at the cutoff: nothing
      send_cube(case_cube(8'h00, 0, 0, 0, 0, -1));      // all outside: nothing
      for (int k = 0; k < 8; k++)
         send_cube(case_cube(1 << k, 5 + k, 3, 7, 100, -100));
      send_cube(case_cube(61, 12, 20, 4, 10, -10));     // fifteen vertices
      send_cube(case_cube(8'h5a, 31, 31, 31, 127, -128));
      send_cube(case_cube(8'ha5, 0, 0, 0, 127, -128));
      send_cube(case_cube(8'h3c, 29, 0, 29, 1, -1));
      send_cube(case_cube(8'h81, 30, 29, 31, 127, -1));
      send_cube(case_cube(8'h7e, 15, 16, 0, 0, -128));
      send_cube(case_cube(8'hc3, 21, 10, 10, 127, 126));

      // Random phases over cutoff and flow-control settings
      cut_set   = '{-128, 127, 0, -1, 0};
      idle_set  = '{87, 0, 9, 0, 0};
      stall_set = '{0, 87, 9, 0, 0};
      cut_set[4] = $urandom_range(255) - 128;
      for (int p = 0; p < 5; p++) begin
         write_cutoff(DENS_W'(cut_set[p]));
         send_idle_pct = idle_set[p];
         rsp_stall_pct = stall_set[p];
         if (p == 3) hold_asked++;
         for (int i = 0; i < 38; i++) send_cube(rand_cube(cut_set[p]));
      end
      req_ch.valid <= 1'b0;

      // Drain and settle
      while (board.pending_verts.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0) begin
         $display("marching_cubes_triangle_emitter verification clean");
      end else begin
         $display("marching_cubes_triangle_emitter verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mcte_pkg.sv
rtl/mcte_if.sv
rtl/mcte_ctrl.sv
rtl/mcte_datapath.sv
rtl/marching_cubes_triangle_emitter.sv
test/marching_cubes_triangle_emitter_test.sv
